// File: sv/fanpwm_pkg.sv
// Shared constants, codes and lookup tables for the fan tacho and PWM controller.
package fanpwm_pkg;

  localparam int unsigned TachoChannels = 24;
  localparam int unsigned PwmChannels   = 4;
  localparam int unsigned MaxCoolState  = 10;

  localparam int unsigned DutyMin = 51;
  localparam int unsigned DutyMax = 255;

  localparam logic [30:0] RpmNum     = 31'd1500000000;
  localparam logic [7:0]  SamplesRst = 8'd44;
  localparam logic [15:0] DividerRst = 16'(283 * 4);
  localparam logic [4:0]  TpdRst     = 5'd0;
  localparam logic [7:0]  FaultRst   = 8'd255;
  localparam logic        ThermEnRst = 1'b1;

  typedef enum logic [2:0] {
    REQ_SPEED     = 3'd0,
    REQ_FAULT     = 3'd1,
    REQ_DUTY_GET  = 3'd2,
    REQ_DUTY_SET  = 3'd3,
    REQ_THERM_SET = 3'd4,
    REQ_THERM_GET = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_INVAL = 2'd1,
    STAT_UNSUP = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_SAMPLES  = 3'd0,
    REG_DIVIDER  = 3'd1,
    REG_TPD      = 3'd2,
    REG_FAULT    = 3'd3,
    REG_THERM_EN = 3'd4
  } reg_addr_e;

  function automatic logic [255:0][3:0] build_d2st();
    logic [255:0][3:0] t;
    for (int d = 0; d < 256; d++) begin
      t[d] = 4'((d * MaxCoolState + DutyMax / 2) / DutyMax);
    end
    return t;
  endfunction

  function automatic logic [15:0][7:0] build_st2duty();
    logic [15:0][7:0] t;
    for (int s = 0; s < 16; s++) begin
      t[s] = 8'((s * DutyMax + MaxCoolState / 2) / MaxCoolState);
    end
    return t;
  endfunction

  localparam logic [255:0][3:0] D2St    = build_d2st();
  localparam logic [15:0][7:0]  St2Duty = build_st2duty();
  localparam logic [3:0]        UserStateRst = D2St[DutyMin];

endpackage

// File: sv/fan_tach_and_pwm_controller.sv
// Fan tacho speed/fault queries and per-channel PWM cooling state, serial rpm datapath.
// PWM, fault, rejected and fault-coded speed requests finish from the decode state.
// Other speed queries: 5-step drawer divide (tpd nonzero), 11-step bit-serial multiply,
// prep, 31-step restoring divide; an absent drawer or a zero denominator ends early.
// A new start is taken in the done cycle, so requests do not overlap; receiver cannot stall.
// Reset (async, active low) restores register defaults and all channel states.
module fan_tach_and_pwm_controller import fanpwm_pkg::*; #(
  parameter int unsigned PWM_CHANNELS = PwmChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  channel_i,
  input  logic [9:0]  value_in_i,
  input  logic [7:0]  drawer_presence_i,
  output logic        done_o,
  output logic [30:0] result_value_o,
  output logic [1:0]  status_o,
  output logic        duty_changed_o,
  output logic [7:0]  duty_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PwmIdxW = (PWM_CHANNELS > 1) ? $clog2(PWM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DRAWER,
    ST_MUL,
    ST_PREP,
    ST_DIV
  } state_e;

  state_e state_q;

  logic [7:0]  samples_q;
  logic [15:0] divider_q;
  logic [4:0]  tpd_q;
  logic [7:0]  fault_q;
  logic        therm_en_q;

  logic [7:0] duty_q  [PWM_CHANNELS];
  logic [3:0] user_q  [PWM_CHANNELS];
  logic [3:0] therm_q [PWM_CHANNELS];

  logic [2:0] type_q;
  logic [4:0] ch_q;
  logic [9:0] val_q;
  logic [7:0] pres_q;

  logic [4:0]  cnt_q;
  logic [4:0]  drw_q;
  logic [4:0]  drw_rem_q;
  logic [10:0] mq_q;
  logic [26:0] acc_q;
  logic [30:0] num_q;
  logic [26:0] rem_q;

  logic        done_q;
  logic [30:0] result_q;
  logic [1:0]  status_q;
  logic        changed_q;
  logic [7:0]  duty_out_q;

  logic        cfg_wr;
  logic        accept;
  logic [PwmIdxW-1:0] idx;
  logic [7:0]  cur_duty;
  logic [3:0]  cur_user;
  logic [3:0]  cur_therm;
  logic [3:0]  arb_s;
  logic [3:0]  ts_s;
  logic        pwm_bad;
  logic        tacho_bad;

  logic [5:0]  drw_trial;
  logic [5:0]  drw_diff;
  logic        drw_ge;
  logic [26:0] mul_next;
  logic [27:0] div_trial;
  logic [27:0] div_diff;
  logic        div_ge;

  assign cfg_wr = psel & penable & pwrite;
  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (reg_addr_e'(paddr[4:2]))
      REG_SAMPLES:  prdata = {24'd0, samples_q};
      REG_DIVIDER:  prdata = {16'd0, divider_q};
      REG_TPD:      prdata = {27'd0, tpd_q};
      REG_FAULT:    prdata = {24'd0, fault_q};
      REG_THERM_EN: prdata = {31'd0, therm_en_q};
      default:      prdata = '0;
    endcase
  end

  assign idx       = ch_q[PwmIdxW-1:0];
  assign cur_duty  = duty_q[idx];
  assign cur_user  = user_q[idx];
  assign cur_therm = therm_q[idx];
  assign arb_s     = D2St[val_q[7:0]];
  assign ts_s      = (cur_user > val_q[3:0]) ? cur_user : val_q[3:0];
  assign pwm_bad   = (32'(ch_q) >= PWM_CHANNELS);
  assign tacho_bad = (32'(ch_q) >= TachoChannels);

  assign drw_trial = {drw_rem_q, drw_q[4]};
  assign drw_diff  = drw_trial - {1'b0, tpd_q};
  assign drw_ge    = (drw_trial >= {1'b0, tpd_q});

  assign mul_next  = {acc_q[25:0], 1'b0} + {11'd0, divider_q & {16{mq_q[10]}}};

  assign div_trial = {rem_q, num_q[30]};
  assign div_diff  = div_trial - {1'b0, acc_q};
  assign div_ge    = (div_trial >= {1'b0, acc_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q  <= SamplesRst;
      divider_q  <= DividerRst;
      tpd_q      <= TpdRst;
      fault_q    <= FaultRst;
      therm_en_q <= ThermEnRst;
    end else if (cfg_wr) begin
      case (reg_addr_e'(paddr[4:2]))
        REG_SAMPLES:  samples_q  <= pwdata[7:0];
        REG_DIVIDER:  divider_q  <= pwdata[15:0];
        REG_TPD:      tpd_q      <= pwdata[4:0];
        REG_FAULT:    fault_q    <= pwdata[7:0];
        REG_THERM_EN: therm_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      result_q   <= '0;
      status_q   <= STAT_OK;
      changed_q  <= 1'b0;
      duty_out_q <= '0;
      type_q     <= '0;
      ch_q       <= '0;
      val_q      <= '0;
      pres_q     <= '0;
      cnt_q      <= '0;
      drw_q      <= '0;
      drw_rem_q  <= '0;
      mq_q       <= '0;
      acc_q      <= '0;
      num_q      <= '0;
      rem_q      <= '0;
      for (int i = 0; i < PWM_CHANNELS; i++) begin
        duty_q[i]  <= '0;
        user_q[i]  <= UserStateRst;
        therm_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            type_q  <= req_type_i;
            ch_q    <= channel_i;
            val_q   <= value_in_i;
            pres_q  <= drawer_presence_i;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          result_q   <= '0;
          status_q   <= STAT_OK;
          changed_q  <= 1'b0;
          duty_out_q <= '0;
          done_q     <= 1'b1;
          state_q    <= ST_IDLE;
          case (type_q)
            REQ_SPEED, REQ_FAULT: begin
              if (tacho_bad) begin
                status_q <= STAT_INVAL;
              end else if (type_q == REQ_FAULT) begin
                result_q <= {30'd0, (val_q == {2'b00, fault_q})};
              end else if (val_q != {2'b00, fault_q}) begin
                done_q <= 1'b0;
                if (tpd_q != '0) begin
                  drw_q     <= ch_q;
                  drw_rem_q <= '0;
                  cnt_q     <= 5'd4;
                  state_q   <= ST_DRAWER;
                end else begin
                  mq_q    <= 11'(val_q) + 11'(samples_q);
                  acc_q   <= '0;
                  cnt_q   <= 5'd10;
                  state_q <= ST_MUL;
                end
              end
            end
            REQ_DUTY_GET, REQ_DUTY_SET, REQ_THERM_SET, REQ_THERM_GET: begin
              if (pwm_bad) begin
                status_q <= STAT_INVAL;
              end else begin
                duty_out_q <= cur_duty;
                case (type_q)
                  REQ_DUTY_GET: result_q <= {23'd0, cur_duty};
                  REQ_THERM_GET: result_q <= {27'd0, D2St[cur_duty]};
                  REQ_DUTY_SET: begin
                    if ((val_q < 10'(DutyMin)) || (val_q > 10'(DutyMax))) begin
                      status_q <= STAT_INVAL;
                    end else if (therm_en_q) begin
                      user_q[idx] <= arb_s;
                      if (arb_s >= cur_therm) begin
                        therm_q[idx] <= arb_s;
                        duty_q[idx]  <= St2Duty[arb_s];
                        duty_out_q   <= St2Duty[arb_s];
                        changed_q    <= 1'b1;
                      end
                    end else begin
                      duty_q[idx] <= val_q[7:0];
                      duty_out_q  <= val_q[7:0];
                      changed_q   <= 1'b1;
                    end
                  end
                  default: begin
                    if (val_q > 10'(MaxCoolState)) begin
                      status_q <= STAT_INVAL;
                    end else begin
                      therm_q[idx] <= val_q[3:0];
                      duty_q[idx]  <= St2Duty[ts_s];
                      duty_out_q   <= St2Duty[ts_s];
                      changed_q    <= 1'b1;
                    end
                  end
                endcase
              end
            end
            default: status_q <= STAT_UNSUP;
          endcase
        end
        ST_DRAWER: begin
          drw_rem_q <= drw_ge ? drw_diff[4:0] : drw_trial[4:0];
          drw_q     <= {drw_q[3:0], drw_ge};
          cnt_q     <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            if ((drw_q[3:2] == 2'b00) && pres_q[{drw_q[1:0], drw_ge}]) begin
              result_q   <= '0;
              status_q   <= STAT_OK;
              changed_q  <= 1'b0;
              duty_out_q <= '0;
              done_q     <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              mq_q    <= 11'(val_q) + 11'(samples_q);
              acc_q   <= '0;
              cnt_q   <= 5'd10;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          acc_q <= mul_next;
          mq_q  <= {mq_q[9:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (acc_q == '0) begin
            result_q   <= RpmNum;
            status_q   <= STAT_OK;
            changed_q  <= 1'b0;
            duty_out_q <= '0;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            num_q   <= RpmNum + {5'd0, acc_q[26:1]};
            rem_q   <= '0;
            cnt_q   <= 5'd30;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? div_diff[26:0] : div_trial[26:0];
          num_q <= {num_q[29:0], div_ge};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            result_q   <= {num_q[29:0], div_ge};
            status_q   <= STAT_OK;
            changed_q  <= 1'b0;
            duty_out_q <= '0;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign duty_changed_o = changed_q;
  assign duty_out_o     = duty_out_q;

endmodule

// File: sv/fanpwm_checker.sv
// Port-level checks for the fan tacho and PWM controller, bound to the top level.
module fanpwm_checker import fanpwm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [30:0] result_value_o,
  input logic [1:0]  status_o,
  input logic        duty_changed_o,
  input logic [7:0]  duty_out_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transfer accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STAT_OK) |-> (result_value_o == '0) && !duty_changed_o)
    else $error("error result carries data");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STAT_OK) || (status_o == STAT_INVAL) ||
               (status_o == STAT_UNSUP))
    else $error("bad status code");

endmodule

bind fan_tach_and_pwm_controller fanpwm_checker u_fanpwm_checker (.*);

// File: dv/fan_tach_and_pwm_controller_test.sv
// Self-checking testbench for the fan tacho and PWM controller: directed table, then random requests.
module fan_tach_and_pwm_controller_test;
  import fanpwm_pkg::*;

  localparam logic [2:0]  ReqUnsupA = 3'd6;
  localparam logic [2:0]  ReqUnsupB = 3'd7;
  localparam int unsigned MaxGap    = 14;
  localparam int unsigned RandItems = 400;
  localparam int unsigned Phases    = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] ch;
    logic [9:0] val;
    logic [7:0] pres;
  } fan_req_t;

  typedef struct packed {
    logic [30:0] value;
    logic [1:0]  status;
    logic        changed;
    logic [7:0]  duty;
  } fan_reply_t;

  typedef struct {
    bit         is_cfg;
    reg_addr_e  addr;
    logic [31:0] data;
    fan_req_t   rq;
    bit         fixed;
    fan_reply_t want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  req_type_i;
  logic [4:0]  channel_i;
  logic [9:0]  value_in_i;
  logic [7:0]  drawer_presence_i;
  logic        done_o;
  logic [30:0] result_value_o;
  logic [1:0]  status_o;
  logic        duty_changed_o;
  logic [7:0]  duty_out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted register file and per-channel cooling state
  logic [7:0]  samples_r;
  logic [15:0] divider_r;
  logic [4:0]  tpd_r;
  logic [7:0]  fault_r;
  logic        therm_en_r;
  logic [7:0]  duty_r  [PwmChannels];
  logic [3:0]  user_r  [PwmChannels];
  logic [3:0]  therm_r [PwmChannels];

  fan_reply_t  pending_replies[$];
  fan_reply_t  head_reply;
  plan_row_t   plan[$];
  int unsigned errors, n_tacho, n_pwm, n_rej, n_cfg;

  fan_tach_and_pwm_controller i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .channel_i         (channel_i),
    .value_in_i        (value_in_i),
    .drawer_presence_i (drawer_presence_i),
    .done_o            (done_o),
    .result_value_o    (result_value_o),
    .status_o          (status_o),
    .duty_changed_o    (duty_changed_o),
    .duty_out_o        (duty_out_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  function automatic logic [3:0] cool_state_of(int unsigned duty);
    return 4'((duty * MaxCoolState + DutyMax / 2) / DutyMax);
  endfunction

  function automatic logic [7:0] duty_of_state(int unsigned st);
    return 8'((st * DutyMax + MaxCoolState / 2) / MaxCoolState);
  endfunction

  function automatic logic [30:0] rpm_of(int unsigned raw);
    longint unsigned den;
    den = (64'(raw) + 64'(samples_r)) * 64'(divider_r);
    if (den == 0) return RpmNum;
    return 31'((64'(RpmNum) + den / 2) / den);
  endfunction

  function automatic fan_reply_t serve_request(fan_req_t rq);
    fan_reply_t  r;
    int unsigned drawer;
    logic [3:0]  st;
    r = '0;
    case (rq.kind)
      REQ_SPEED, REQ_FAULT: begin
        if (32'(rq.ch) >= TachoChannels) begin
          r.status = STAT_INVAL;
        end else if (rq.kind == REQ_FAULT) begin
          r.value = 31'(rq.val == 10'(fault_r));
        end else begin
          // drawers past the presence word always count as present
          drawer = (tpd_r != 0) ? 32'(rq.ch) / 32'(tpd_r) : 8;
          if (!(drawer < 8 && rq.pres[drawer[2:0]]) && rq.val != 10'(fault_r))
            r.value = rpm_of(32'(rq.val));
        end
      end
      REQ_DUTY_GET, REQ_DUTY_SET, REQ_THERM_SET, REQ_THERM_GET: begin
        if (32'(rq.ch) >= PwmChannels) begin
          r.status = STAT_INVAL;
        end else begin
          case (rq.kind)
            REQ_DUTY_GET: r.value = 31'(duty_r[rq.ch]);
            REQ_DUTY_SET: begin
              if (32'(rq.val) < DutyMin || 32'(rq.val) > DutyMax) begin
                r.status = STAT_INVAL;
              end else if (therm_en_r) begin
                user_r[rq.ch] = cool_state_of(32'(rq.val));
                if (user_r[rq.ch] >= therm_r[rq.ch]) begin
                  therm_r[rq.ch] = user_r[rq.ch];
                  duty_r[rq.ch]  = duty_of_state(32'(user_r[rq.ch]));
                  r.changed      = 1'b1;
                end
              end else begin
                duty_r[rq.ch] = rq.val[7:0];
                r.changed     = 1'b1;
              end
            end
            REQ_THERM_SET: begin
              if (32'(rq.val) > MaxCoolState) begin
                r.status = STAT_INVAL;
              end else begin
                therm_r[rq.ch] = rq.val[3:0];
                st = (user_r[rq.ch] > rq.val[3:0]) ? user_r[rq.ch] : rq.val[3:0];
                duty_r[rq.ch] = duty_of_state(32'(st));
                r.changed     = 1'b1;
              end
            end
            default: r.value = 31'(cool_state_of(32'(duty_r[rq.ch])));
          endcase
          r.duty = duty_r[rq.ch];
        end
      end
      default: r.status = STAT_UNSUP;
    endcase
    return r;
  endfunction

  function automatic fan_req_t draw_request();
    fan_req_t    rq;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    rq.pres = 8'($urandom);
    rq.val  = 10'($urandom);
    rq.ch   = 5'($urandom_range(0, PwmChannels - 1));
    if ($urandom_range(0, 9) == 0) rq.ch = 5'($urandom_range(PwmChannels, 31));
    if (pick < 45) begin
      rq.kind = (pick < 35) ? REQ_SPEED : REQ_FAULT;
      rq.ch   = 5'($urandom_range(0, TachoChannels - 1));
      if ($urandom_range(0, 9) == 0) rq.ch = 5'($urandom_range(TachoChannels, 31));
      if ($urandom_range(0, 4) == 0) rq.val = 10'(fault_r);
    end else if (pick < 55) begin
      rq.kind = REQ_DUTY_GET;
    end else if (pick < 72) begin
      rq.kind = REQ_DUTY_SET;
      if ($urandom_range(0, 4) != 0) rq.val = 10'($urandom_range(DutyMin, DutyMax));
    end else if (pick < 85) begin
      rq.kind = REQ_THERM_SET;
      if ($urandom_range(0, 4) != 0) rq.val = 10'($urandom_range(0, MaxCoolState));
    end else if (pick < 95) begin
      rq.kind = REQ_THERM_GET;
    end else begin
      rq.kind = $urandom_range(0, 1) ? ReqUnsupA : ReqUnsupB;
      rq.ch   = 5'($urandom);
    end
    return rq;
  endfunction

  function automatic plan_row_t req_row(logic [2:0] k, int unsigned ch, int unsigned val,
                                        int unsigned pres);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.addr   = REG_SAMPLES;
    row.data   = '0;
    row.rq     = '{kind: k, ch: 5'(ch), val: 10'(val), pres: 8'(pres)};
    row.fixed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic plan_row_t chk_row(logic [2:0] k, int unsigned ch, int unsigned val,
                                        int unsigned pres, logic [30:0] value,
                                        logic [1:0] status, logic chg, logic [7:0] duty);
    plan_row_t row;
    row       = req_row(k, ch, val, pres);
    row.fixed = 1'b1;
    row.want  = '{value: value, status: status, changed: chg, duty: duty};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(reg_addr_e a, int unsigned d);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.addr   = a;
    row.data   = d;
    row.rq     = '0;
    row.fixed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_addr_e a, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {a, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (a)
      REG_SAMPLES:  samples_r  = d[7:0];
      REG_DIVIDER:  divider_r  = d[15:0];
      REG_TPD:      tpd_r      = d[4:0];
      REG_FAULT:    fault_r    = d[7:0];
      REG_THERM_EN: therm_en_r = d[0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic issue(fan_req_t rq, int unsigned gap, bit fixed, fan_reply_t want);
    fan_reply_t got;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    req_type_i        <= rq.kind;
    channel_i         <= rq.ch;
    value_in_i        <= rq.val;
    drawer_presence_i <= rq.pres;
    do @(posedge clk_i); while (busy);
    got = serve_request(rq);
    pending_replies.push_back(fixed ? want : got);
    if (got.status != STAT_OK) n_rej++;
    else if (rq.kind == REQ_SPEED || rq.kind == REQ_FAULT) n_tacho++;
    else n_pwm++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
      end else begin
        head_reply = pending_replies.pop_front();
        check_field("result_value", 64'(head_reply.value), 64'(result_value_o));
        check_field("status", 64'(head_reply.status), 64'(status_o));
        check_field("duty_changed", 64'(head_reply.changed), 64'(duty_changed_o));
        check_field("duty_out", 64'(head_reply.duty), 64'(duty_out_o));
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    start             = 1'b0;
    req_type_i        = '0;
    channel_i         = '0;
    value_in_i        = '0;
    drawer_presence_i = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    samples_r         = SamplesRst;
    divider_r         = DividerRst;
    tpd_r             = TpdRst;
    fault_r           = FaultRst;
    therm_en_r        = ThermEnRst;
    for (int c = 0; c < PwmChannels; c++) begin
      duty_r[c]  = '0;
      user_r[c]  = cool_state_of(DutyMin);
      therm_r[c] = '0;
    end

    plan.push_back(chk_row(REQ_DUTY_GET, 0, 0, 0, 0, STAT_OK, 0, 0));
    plan.push_back(chk_row(REQ_THERM_GET, 3, 0, 0, 0, STAT_OK, 0, 0));
    plan.push_back(req_row(REQ_SPEED, 0, 0, 8'hff));
    plan.push_back(req_row(REQ_SPEED, 23, 1023, 0));
    plan.push_back(chk_row(REQ_SPEED, 5, 255, 0, 0, STAT_OK, 0, 0));
    plan.push_back(chk_row(REQ_FAULT, 1, 255, 0, 1, STAT_OK, 0, 0));
    plan.push_back(chk_row(REQ_FAULT, 1, 1023, 0, 0, STAT_OK, 0, 0));
    plan.push_back(chk_row(REQ_SPEED, 24, 7, 0, 0, STAT_INVAL, 0, 0));
    plan.push_back(chk_row(REQ_FAULT, 31, 255, 0, 0, STAT_INVAL, 0, 0));
    plan.push_back(chk_row(REQ_DUTY_SET, 0, 50, 0, 0, STAT_INVAL, 0, 0));
    plan.push_back(chk_row(REQ_DUTY_SET, 0, 256, 0, 0, STAT_INVAL, 0, 0));
    plan.push_back(chk_row(REQ_DUTY_SET, 0, 51, 0, 0, STAT_OK, 1, 51));
    plan.push_back(chk_row(REQ_DUTY_SET, 1, 255, 0, 0, STAT_OK, 1, 255));
    plan.push_back(chk_row(REQ_THERM_SET, 1, 11, 0, 0, STAT_INVAL, 0, 255));
    plan.push_back(req_row(REQ_THERM_SET, 2, 10, 0));
    // user state below thermal state: duty stays
    plan.push_back(req_row(REQ_DUTY_SET, 2, 100, 0));
    plan.push_back(req_row(REQ_THERM_GET, 2, 0, 0));
    plan.push_back(req_row(REQ_THERM_SET, 3, 0, 0));
    plan.push_back(chk_row(ReqUnsupA, 0, 0, 0, 0, STAT_UNSUP, 0, 0));
    plan.push_back(chk_row(ReqUnsupB, 31, 1023, 8'hff, 0, STAT_UNSUP, 0, 0));
    plan.push_back(chk_row(REQ_DUTY_GET, 4, 0, 0, 0, STAT_INVAL, 0, 0));
    plan.push_back(chk_row(REQ_THERM_SET, 31, 5, 0, 0, STAT_INVAL, 0, 0));
    plan.push_back(cfg_row(REG_TPD, 1));
    plan.push_back(cfg_row(REG_THERM_EN, 0));
    plan.push_back(cfg_row(REG_FAULT, 0));
    plan.push_back(chk_row(REQ_SPEED, 3, 9, 8'h08, 0, STAT_OK, 0, 0));
    plan.push_back(req_row(REQ_SPEED, 9, 9, 8'hff));
    plan.push_back(req_row(REQ_DUTY_SET, 3, 200, 0));
    plan.push_back(cfg_row(REG_SAMPLES, 0));
    plan.push_back(cfg_row(REG_FAULT, 255));
    plan.push_back(cfg_row(REG_TPD, 24));
    plan.push_back(cfg_row(REG_DIVIDER, 65535));
    // zero denominator saturates
    plan.push_back(chk_row(REQ_SPEED, 0, 0, 8'hfe, RpmNum, STAT_OK, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        cfg_write(plan[i].addr, plan[i].data);
      end else begin
        issue(plan[i].rq, $urandom_range(0, MaxGap), plan[i].fixed, plan[i].want);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      wait_drained();
      cfg_write(REG_SAMPLES,  p == 1 ? 1 : p == 2 ? 255   : $urandom_range(1, 255));
      cfg_write(REG_DIVIDER,  p == 1 ? 1 : p == 2 ? 65535 : $urandom_range(1, 65535));
      cfg_write(REG_TPD,      p == 1 ? 0 : p == 2 ? 24    : $urandom_range(0, 24));
      cfg_write(REG_FAULT,    p == 1 ? 0 : p == 2 ? 255   : $urandom_range(0, 255));
      cfg_write(REG_THERM_EN, p == 1 ? 0 : p == 2 ? 1     : $urandom_range(0, 1));
      for (int k = 0; k < RandItems / Phases; k++) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        issue(draw_request(), (p % 3 == 0) ? 0 : $urandom_range(0, MaxGap), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Checked %0d tacho, %0d pwm and %0d rejected requests", n_tacho, n_pwm, n_rej);
    $display("under %0d register writes, including both range extremes", n_cfg);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
